@@ rtl/kvt_pkg.sv @@
// kvt_pkg: shared constants, codes and types of the key/value table
`timescale 1ns / 1ps
`default_nettype none
package kvt_pkg;

  // fixed field widths on the streaming ports
  localparam int OPCODE_W      = 2;
  localparam int KEY_FIELD_W   = 32;
  localparam int VALUE_FIELD_W = 32;
  localparam int STATUS_W      = 3;
  localparam int COUNT_FIELD_W = 7;
  localparam int IN_TDATA_W    = 64;
  localparam int OUT_TDATA_W   = 40;

  // parameter defaults
  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // per-cell write controls for one execute cycle
  typedef struct packed {
    logic shift;     // take the upper neighbor's entry
    logic load_key;  // write a new key and value
    logic load_val;  // overwrite the value only
  } cell_ctl_t;

endpackage : kvt_pkg
`default_nettype wire

@@ rtl/kvt_cell.sv @@
// kvt_cell: one table slot with its key compare and neighbor shift path
`timescale 1ns / 1ps
`default_nettype none
module kvt_cell #(
  parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cmp_en,
  input  wire logic                  live,
  input  wire logic [KEY_BITS-1:0]   cmp_key,
  input  wire kvt_pkg::cell_ctl_t    ctl,
  input  wire logic [KEY_BITS-1:0]   wr_key,
  input  wire logic [VALUE_BITS-1:0] wr_val,
  input  wire logic [KEY_BITS-1:0]   nb_key,
  input  wire logic [VALUE_BITS-1:0] nb_val,
  output logic [KEY_BITS-1:0]        key_q,
  output logic [VALUE_BITS-1:0]      val_q,
  output logic                       hit,
  output logic [VALUE_BITS-1:0]      hit_val
);
  import kvt_pkg::*;

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmp_en) begin
      hit_r <= live && (key_r == cmp_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r <= nb_key;
      val_r <= nb_val;
    end else if (ctl.load_key) begin
      key_r <= wr_key;
      val_r <= wr_val;
    end else if (ctl.load_val) begin
      val_r <= wr_val;
    end
  end

  assign key_q   = key_r;
  assign val_q   = val_r;
  assign hit     = hit_r;
  assign hit_val = hit_r ? val_r : '0;

endmodule : kvt_cell
`default_nettype wire

@@ rtl/key_value_table.sv @@
// key_value_table: top level, row of table cells with the request sequencer
//
// A fixed-capacity key/value table. Requests enter on the in_ stream: in_tuser
// carries the opcode (insert/update, lookup, remove), in_tdata the key and the
// value. Every request yields exactly one result on the out_ stream: out_tuser
// carries the status, out_tdata the looked-up value and the live entry count.
// Each cell holds one slot; all cells compare the key in parallel in the cycle
// a request is accepted, and the execute state then applies the write, the
// update or the remove shift, where the removed slot and each live cell above
// it take their upper neighbor's entry. No new request is accepted until the
// execute state of the last one has changed the cells.
// The next request is accepted while a finished result still waits in the
// output register; when the receiver stalls, the execute cycle of that next
// request holds until the output register is free, and in_tready stays low.
// Reset empties the table (count zero) and clears both handshake sides; the
// slot contents need no clearing since only live slots are ever compared.
`timescale 1ns / 1ps
`default_nettype none
module key_value_table #(
  parameter int CAPACITY   = kvt_pkg::CAPACITY_DEF,
  parameter int KEY_BITS   = kvt_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [31:0] key_in, [63:32] value_in
  input  wire logic [kvt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] opcode
  input  wire logic [kvt_pkg::OPCODE_W-1:0]      in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] value_out, [38:32] entry_count, [39] zero
  output logic [kvt_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // [2:0] status
  output logic [kvt_pkg::STATUS_W-1:0]           out_tuser
);
  import kvt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;
  logic   accept;
  logic   exec_go;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [OPCODE_W-1:0]   op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_val;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [VALUE_BITS-1:0] vout_r, vout_nxt;

  logic [CAPACITY-1:0]   live;
  logic [CAPACITY-1:0]   hit_vec;
  logic [CAPACITY-1:0]   at_hit_up;
  logic                  any_hit;
  logic                  full;
  logic [VALUE_BITS-1:0] hit_val_or;
  logic                  do_append;
  logic                  do_update;
  logic                  do_remove;

  logic [KEY_BITS-1:0]   cell_key [CAPACITY];
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic [VALUE_BITS-1:0] cell_hv  [CAPACITY];
  cell_ctl_t             cell_ctl [CAPACITY];

  // field width adaptation between ports and storage
  generate
    if (KEY_BITS <= KEY_FIELD_W) begin : g_key_cut
      assign in_key = in_tdata[KEY_BITS-1:0];
    end else begin : g_key_ext
      assign in_key = {{(KEY_BITS-KEY_FIELD_W){1'b0}}, in_tdata[KEY_FIELD_W-1:0]};
    end
    if (VALUE_BITS <= VALUE_FIELD_W) begin : g_val_cut
      assign in_val = in_tdata[KEY_FIELD_W +: VALUE_BITS];
      assign out_tdata[VALUE_FIELD_W-1:0] = VALUE_FIELD_W'(vout_r);
    end else begin : g_val_ext
      assign in_val = {{(VALUE_BITS-VALUE_FIELD_W){1'b0}},
                       in_tdata[KEY_FIELD_W +: VALUE_FIELD_W]};
      assign out_tdata[VALUE_FIELD_W-1:0] = vout_r[VALUE_FIELD_W-1:0];
    end
    if (CNT_W >= COUNT_FIELD_W) begin : g_cnt_cut
      assign out_tdata[VALUE_FIELD_W +: COUNT_FIELD_W] = count_r[COUNT_FIELD_W-1:0];
    end else begin : g_cnt_ext
      assign out_tdata[VALUE_FIELD_W +: COUNT_FIELD_W] =
        {{(COUNT_FIELD_W-CNT_W){1'b0}}, count_r};
    end
  endgenerate
  assign out_tdata[OUT_TDATA_W-1:VALUE_FIELD_W+COUNT_FIELD_W] = '0;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    exec_go   = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_EXEC: exec_go = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        exec_go   = 1'b0;
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tuser;
      key_r <= in_key;
      val_r <= in_val;
    end
  end

  // match reduction; live keys are unique so at most one cell hits
  assign any_hit = |hit_vec;
  // thermometer: the hit slot and every slot above it
  assign at_hit_up = ~(hit_vec - CAPACITY'(1));
  assign full      = (count_r >= CNT_W'(CAPACITY));

  always_comb begin
    hit_val_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_val_or = hit_val_or | cell_hv[i];
    end
  end

  always_comb begin
    do_append  = 1'b0;
    do_update  = 1'b0;
    do_remove  = 1'b0;
    status_nxt = ST_NOT_FOUND;
    vout_nxt   = '0;
    count_nxt  = count_r;
    priority if (op_r == OP_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else if (any_hit) begin
        status_nxt = ST_UPDATED;
        do_update  = exec_go;
      end else begin
        status_nxt = ST_APPENDED;
        do_append  = exec_go;
        count_nxt  = count_r + CNT_W'(1);
      end
    end else if (op_r == OP_LOOKUP) begin
      if (any_hit) begin
        status_nxt = ST_FOUND;
        vout_nxt   = hit_val_or;
      end
    end else if (op_r == OP_REMOVE) begin
      if (any_hit) begin
        status_nxt = ST_REMOVED;
        do_remove  = exec_go;
        count_nxt  = count_r - CNT_W'(1);
      end
    end else begin
      status_nxt = ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (exec_go) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      status_r <= status_nxt;
      vout_r   <= vout_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;

  // row of cells
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0]   nb_key;
      logic [VALUE_BITS-1:0] nb_val;

      if (i < CAPACITY - 1) begin : g_nb
        assign nb_key = cell_key[i+1];
        assign nb_val = cell_val[i+1];
      end else begin : g_top
        assign nb_key = cell_key[i];
        assign nb_val = cell_val[i];
      end

      assign live[i]              = (CNT_W'(i) < count_r);
      assign cell_ctl[i].shift    = do_remove && at_hit_up[i] && live[i];
      assign cell_ctl[i].load_key = do_append && (count_r == CNT_W'(i));
      assign cell_ctl[i].load_val = do_update && hit_vec[i];

      kvt_cell #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmp_en  (accept),
        .live    (live[i]),
        .cmp_key (in_key),
        .ctl     (cell_ctl[i]),
        .wr_key  (key_r),
        .wr_val  (val_r),
        .nb_key  (nb_key),
        .nb_val  (nb_val),
        .key_q   (cell_key[i]),
        .val_q   (cell_val[i]),
        .hit     (hit_vec[i]),
        .hit_val (cell_hv[i])
      );
    end
  endgenerate

endmodule : key_value_table
`default_nettype wire

@@ rtl/kvt_checker.sv @@
// kvt_checker: port-level assertions for the key/value table, bound to the top
`timescale 1ns / 1ps
`default_nettype none
module kvt_checker #(
  parameter int CAPACITY = kvt_pkg::CAPACITY_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [kvt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [kvt_pkg::STATUS_W-1:0]   out_tuser
);
  import kvt_pkg::*;

  // an accepted request moves the sequencer into its execute state, so ready drops right after an accept
  a_ready_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready high in the cycle after a request was accepted");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed or dropped");

  // a full reject only happens at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FULL) |->
      (out_tdata[VALUE_FIELD_W +: COUNT_FIELD_W] == COUNT_FIELD_W'(CAPACITY)))
    else $error("full status with the table not at capacity");

  // only a lookup hit carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_FOUND) |->
      (out_tdata[VALUE_FIELD_W-1:0] == '0))
    else $error("nonzero value on a result other than found");

  // results never come out before a request was taken
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a request in execution");

endmodule : kvt_checker

bind key_value_table kvt_checker #(.CAPACITY(CAPACITY)) u_kvt_checker (.*);
`default_nettype wire
